[sv/csc_pkg.sv]
// ----------------------------------------------------------------------------
// Colour sorter classifier package
// Shared word types, register indexes, colour codes and the fixed-point
// colour decision used by the classifier core.
// ----------------------------------------------------------------------------
package csc_pkg;

  // Operation codes carried by an input word
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BG_RED        = 3'd0,
    REG_BG_GREEN      = 3'd1,
    REG_BG_BLUE       = 3'd2,
    REG_SERVO_STEP    = 3'd3,
    REG_HOLDOFF_TICKS = 3'd4
  } cfg_reg_e;

  // Register reset values
  localparam logic [15:0] BG_RED_RESET        = 16'd89;
  localparam logic [15:0] BG_GREEN_RESET      = 16'd66;
  localparam logic [15:0] BG_BLUE_RESET       = 16'd59;
  localparam logic [7:0]  SERVO_STEP_RESET    = 8'd10;
  localparam logic [9:0]  HOLDOFF_TICKS_RESET = 10'd300;

  // Servo pulse widths in microseconds
  localparam logic [11:0] POS_RESET    = 12'd600;
  localparam logic [11:0] TARGET_RESET = 12'd1600;
  localparam logic [11:0] ANGLE_GREEN  = 12'd1230;
  localparam logic [11:0] ANGLE_YELLOW = 12'd1810;
  localparam logic [11:0] ANGLE_ORANGE = 12'd2010;
  localparam logic [11:0] ANGLE_RED    = 12'd1600;
  localparam logic [11:0] ANGLE_PURPLE = 12'd1420;

  // Colour classes
  localparam int unsigned NumClasses = 5;
  localparam int unsigned ClassIdxW  = $clog2(NumClasses);

  typedef enum logic [2:0] {
    COL_GREEN  = 3'd0,
    COL_YELLOW = 3'd1,
    COL_ORANGE = 3'd2,
    COL_RED    = 3'd3,
    COL_PURPLE = 3'd4
  } colour_e;

  // Input word
  typedef struct packed {
    logic        operation;
    logic [15:0] red_raw;
    logic [15:0] green_raw;
    logic [15:0] blue_raw;
    logic [15:0] clear_raw;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [11:0] servo_pulse_us;
    logic        sorted_now;
    logic [2:0]  colour_class;
    logic [15:0] class_count;
    logic        foreground;
  } out_word_t;

  // Decide the colour of a reading with cross-multiplied thresholds.
  // All forms are rearranged so both sides stay non-negative.
  function automatic colour_e classify_colour(logic [15:0] r, logic [15:0] g,
                                              logic [15:0] b, logic [15:0] c);
    logic [28:0] rx;
    logic [28:0] gx;
    logic [28:0] bx;
    logic [28:0] cx;
    colour_e     res;
    rx = 29'(r);
    gx = 29'(g);
    bx = 29'(b);
    cx = 29'(c);
    if (rx * 29'd2560 < cx * 29'd1102) begin
      res = COL_GREEN;
    end else if (gx * 29'd2560 > cx * 29'd844) begin
      res = COL_YELLOW;
    end else if ((bx * 29'd50 >= gx * 29'd27 + 29'd1120) &&
                 (gx * 29'd67 + 29'd1460 >= bx * 29'd100)) begin
      res = COL_ORANGE;
    end else if (bx * 29'd31 <= rx * 29'd10 + 29'd944) begin
      res = COL_RED;
    end else begin
      res = COL_PURPLE;
    end
    return res;
  endfunction

  // Servo target for a colour class
  function automatic logic [11:0] class_angle(colour_e col);
    logic [11:0] ang;
    case (col)
      COL_GREEN:  ang = ANGLE_GREEN;
      COL_YELLOW: ang = ANGLE_YELLOW;
      COL_ORANGE: ang = ANGLE_ORANGE;
      COL_RED:    ang = ANGLE_RED;
      COL_PURPLE: ang = ANGLE_PURPLE;
      default:    ang = TARGET_RESET;
    endcase
    return ang;
  endfunction

endpackage

[sv/csc_if.sv]
// ----------------------------------------------------------------------------
// Colour sorter classifier channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface csc_in_if import csc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface csc_out_if import csc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/color_sorter_classifier_core.sv]
// ----------------------------------------------------------------------------
// Colour sorter classifier core
// Latches colour samples, flags foreground readings, classifies them on
// ticks, drives the servo pulse width and keeps saturating class counts.
// ----------------------------------------------------------------------------
// The core takes one word per clock cycle while the result register is free
// or being read, and returns exactly one result word for each, through the
// input register and then the result register. All per-word work (foreground
// test, colour decision, servo step, count update) is combinational logic
// between those two registers, and state written by one word is seen by the
// very next one. A sample's colour is decided when the sample is latched, so
// a tick only looks up the stored class. Configuration registers are written
// through cfg_we_i/cfg_idx_i/cfg_wdata_i while the core is idle; the user must
// keep to this as the core does not enforce it. Unknown indexes are ignored.
// COUNT_WIDTH is the saturating class counter width; the result shows low 16 bits.
module color_sorter_classifier_core import csc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  csc_in_if.sink              in_if,
  csc_out_if.source           out_if
);

  // Configuration registers
  logic [15:0] bg_red_q, bg_green_q, bg_blue_q;
  logic [7:0]  servo_step_q;
  logic [9:0]  holdoff_ticks_q;

  // Pipeline registers
  logic      in_valid_q;
  in_word_t  in_data_q;
  logic      out_valid_q;
  out_word_t out_data_q, out_data_d;
  logic      advance;
  logic      proc_en;

  // Core state
  logic [11:0]            pos_q, pos_d;
  logic [11:0]            tgt_q, tgt_d;
  logic                   ident_en_q, ident_en_d;
  logic [9:0]             holdoff_q, holdoff_d;
  logic                   pending_q, pending_d;
  colour_e                latched_col_q, latched_col_d;
  logic [COUNT_WIDTH-1:0] count_q [NumClasses];
  logic [COUNT_WIDTH-1:0] cnt_cur, cnt_new;
  logic [31:0]            cnt_wide;
  logic [ClassIdxW-1:0]   cls_idx;
  logic                   do_sort;

  // Sample path signals
  logic        fg_red, fg_green, fg_blue;
  colour_e     sample_col;

  // Servo step signals
  logic [12:0] pos_up;
  logic [11:0] pos_dn;

  // Handshake: the input register moves whenever the result register frees
  assign advance     = !out_valid_q || out_if.ready;
  assign proc_en     = advance && in_valid_q;
  assign in_if.ready = !in_valid_q || advance;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

  // Foreground: squared distance reaches 4 exactly when some channel is at least 2 away
  assign fg_red   = (17'(in_data_q.red_raw) >= 17'(bg_red_q) + 17'd2) ||
                    (17'(bg_red_q) >= 17'(in_data_q.red_raw) + 17'd2);
  assign fg_green = (17'(in_data_q.green_raw) >= 17'(bg_green_q) + 17'd2) ||
                    (17'(bg_green_q) >= 17'(in_data_q.green_raw) + 17'd2);
  assign fg_blue  = (17'(in_data_q.blue_raw) >= 17'(bg_blue_q) + 17'd2) ||
                    (17'(bg_blue_q) >= 17'(in_data_q.blue_raw) + 17'd2);

  // Decide the colour while the sample is latched
  assign sample_col = classify_colour(in_data_q.red_raw, in_data_q.green_raw,
                                      in_data_q.blue_raw, in_data_q.clear_raw);

  // Saturating count of the stored class
  assign do_sort  = (in_data_q.operation == OP_TICK) && ident_en_q &&
                    (holdoff_q == 10'd0) && pending_q;
  assign cls_idx  = ClassIdxW'(latched_col_q);
  assign cnt_cur  = count_q[cls_idx];
  assign cnt_new  = (cnt_cur == {COUNT_WIDTH{1'b1}}) ? cnt_cur :
                    cnt_cur + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
  assign cnt_wide = 32'(cnt_new);

  // Work out the next state and result for the word in the input register
  always_comb begin
    pos_d         = pos_q;
    tgt_d         = tgt_q;
    ident_en_d    = ident_en_q;
    holdoff_d     = holdoff_q;
    pending_d     = pending_q;
    latched_col_d = latched_col_q;
    out_data_d.sorted_now   = 1'b0;
    out_data_d.colour_class = 3'd0;
    out_data_d.class_count  = 16'd0;
    pos_up = 13'd0;
    pos_dn = 12'd0;

    if (in_data_q.operation == OP_SAMPLE) begin
      latched_col_d = sample_col;
      pending_d     = fg_red || fg_green || fg_blue;
    end else begin
      // Classify or count down the holdoff
      if (do_sort) begin
        tgt_d      = class_angle(latched_col_q);
        pending_d  = 1'b0;
        ident_en_d = 1'b0;
        holdoff_d  = holdoff_ticks_q;
        out_data_d.sorted_now   = 1'b1;
        out_data_d.colour_class = latched_col_q;
        out_data_d.class_count  = cnt_wide[15:0];
      end else if (holdoff_q != 10'd0) begin
        holdoff_d = holdoff_q - 10'd1;
      end

      // Step the servo toward the target, clamped at the target
      pos_up = 13'(pos_q) + 13'(servo_step_q);
      pos_dn = (pos_q >= 12'(servo_step_q)) ? pos_q - 12'(servo_step_q) : 12'd0;
      if (pos_q == tgt_d) begin
        ident_en_d = 1'b1;
      end else if (pos_q < tgt_d) begin
        pos_d = (pos_up > 13'(tgt_d)) ? tgt_d : pos_up[11:0];
      end else begin
        pos_d = (pos_dn < tgt_d) ? tgt_d : pos_dn;
      end
    end

    out_data_d.servo_pulse_us = pos_d;
    out_data_d.foreground     = pending_d;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_red_q        <= BG_RED_RESET;
      bg_green_q      <= BG_GREEN_RESET;
      bg_blue_q       <= BG_BLUE_RESET;
      servo_step_q    <= SERVO_STEP_RESET;
      holdoff_ticks_q <= HOLDOFF_TICKS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BG_RED:        bg_red_q        <= cfg_wdata_i;
        REG_BG_GREEN:      bg_green_q      <= cfg_wdata_i;
        REG_BG_BLUE:       bg_blue_q       <= cfg_wdata_i;
        REG_SERVO_STEP:    servo_step_q    <= cfg_wdata_i[7:0];
        REG_HOLDOFF_TICKS: holdoff_ticks_q <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // Pipeline valid bits and core state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      pos_q         <= POS_RESET;
      tgt_q         <= TARGET_RESET;
      ident_en_q    <= 1'b1;
      holdoff_q     <= 10'd0;
      pending_q     <= 1'b0;
      latched_col_q <= COL_RED;
      for (int i = 0; i < NumClasses; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      if (in_if.ready) begin
        in_valid_q <= in_if.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (proc_en) begin
        pos_q         <= pos_d;
        tgt_q         <= tgt_d;
        ident_en_q    <= ident_en_d;
        holdoff_q     <= holdoff_d;
        pending_q     <= pending_d;
        latched_col_q <= latched_col_d;
        if (do_sort) begin
          count_q[cls_idx] <= cnt_new;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_data_q <= in_if.data;
    end
    if (proc_en) begin
      out_data_q <= out_data_d;
    end
  end

`ifndef ASSERT_OFF
  // A classified word always leaves no pending foreground reading
  a_sorted_clears_fg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.sorted_now) |-> !out_data_q.foreground)
    else $error("sorted word still shows a pending foreground reading");

  // No classification while the holdoff is still running
  a_holdoff_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_en && (in_data_q.operation == OP_TICK) && (holdoff_q != 10'd0))
      |=> !out_data_q.sorted_now)
    else $error("classification during holdoff");

  // Unsorted words carry zero class and count
  a_unsorted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q.sorted_now) |->
      (out_data_q.colour_class == 3'd0 && out_data_q.class_count == 16'd0))
    else $error("unsorted word carries class data");
`endif

endmodule
